// ===== rtl/pawc_pkg.sv =====
package pawc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 31;
  localparam int INTEG_W   = 48;
  localparam int ERR_W     = 33;
  localparam int NUM_W     = 34;
  localparam int TERM_W    = 64;
  localparam int MAG_W     = 64;
  localparam int HALF_W    = 32;
  localparam int ACC_W     = 96;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 3'd4;

  localparam logic [GAIN_W-1:0]        GAIN_P_RST   = 31'd65536;
  localparam logic [GAIN_W-1:0]        GAIN_I_RST   = 31'd0;
  localparam logic [GAIN_W-1:0]        GAIN_D_RST   = 31'd0;
  localparam logic signed [DATA_W-1:0] OUT_LOW_RST  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] OUT_HIGH_RST = 32'sh7FFF_FFFF;

  // product magnitude cap, 2^61
  localparam logic [ACC_W-1:0] MAG_CAP = 96'h0000_0000_2000_0000_0000_0000;

  localparam logic signed [TERM_W-1:0] INT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [TERM_W-1:0] INT48_LO = 64'shFFFF_8000_0000_0000;
  localparam logic signed [ERR_W-1:0]  ERR32_HI = 33'sh0_7FFF_FFFF;
  localparam logic signed [ERR_W-1:0]  ERR32_LO = 33'sh1_8000_0000;

  function automatic logic signed [TERM_W-1:0] clamp64(input logic signed [TERM_W-1:0] v,
                                                       input logic signed [TERM_W-1:0] lo,
                                                       input logic signed [TERM_W-1:0] hi);
    logic signed [TERM_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [TERM_W-1:0] v);
    logic signed [TERM_W-1:0] r;
    r = clamp64(v, INT48_LO, INT48_HI);
    return $signed(r[INTEG_W-1:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ERR_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > ERR32_HI) begin
      r = ERR32_HI;
    end else if (v < ERR32_LO) begin
      r = ERR32_LO;
    end else begin
      r = v;
    end
    return $signed(r[DATA_W-1:0]);
  endfunction

endpackage

// ===== rtl/pawc_mul.sv =====
module pawc_mul
  import pawc_pkg::*;
(
  input  logic                clk,
  input  logic [HALF_W-1:0]   a,
  input  logic [HALF_W-1:0]   b,
  output logic [2*HALF_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== rtl/pawc_div.sv =====
module pawc_div
  import pawc_pkg::*;
#(
  parameter int DIV_W = NUM_W + FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DIV_W-1:0]        mag,
  input  logic                    neg,
  input  logic [DATA_W-1:0]       divisor,
  output logic                    done,
  output logic signed [DIV_W:0]   quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvsr_r, dvsr_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // restoring division, one quotient bit a cycle; quotient shifts in as dividend shifts out
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr_r};
  assign ge    = !diff[DATA_W+1];

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = mag;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      neg_nxt  = neg;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dq_nxt  = {dq_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

endmodule

// ===== rtl/pid_anti_windup_controller.sv =====
// Sequence: a full step runs the P, T, LO, HI, I, DV and D operations in that order;
//   gain_i zero skips LO, HI and I, a zero stored error skips DV and D, and a zero
//   timestep gives a zero drive without running any operation.
// Throughput: one item at a time; the radix-2 divider runs up to three times per item.
// Reset (rst_n low, synchronous): gains and limits to defaults, integral and stored error
//   cleared, output empty.
module pid_anti_windup_controller
  import pawc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic signed [DATA_W-1:0] in_sensed,
  input  logic [DATA_W-1:0]        in_step_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_drive,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int DIV_W = NUM_W + FRAC_BITS;
  localparam int QUO_W = DIV_W + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LOAD  = 10'b00_0000_0010,
    S_MLO   = 10'b00_0000_0100,
    S_MHI   = 10'b00_0000_1000,
    S_MACC  = 10'b00_0001_0000,
    S_MFIN  = 10'b00_0010_0000,
    S_DWAIT = 10'b00_0100_0000,
    S_SUM   = 10'b00_1000_0000,
    S_CLAMP = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_P, OP_T, OP_LO, OP_HI, OP_I, OP_DV, OP_D
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // configuration
  logic [GAIN_W-1:0]        gain_p_r, gain_i_r, gain_d_r;
  logic signed [DATA_W-1:0] out_low_r, out_high_r;

  // kept state
  logic signed [INTEG_W-1:0] integral_r, integral_nxt;
  logic signed [DATA_W-1:0]  prev_err_r, prev_err_nxt;

  // item and working registers
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [NUM_W-1:0]   num_r, num_nxt;
  logic [DATA_W-1:0]         dt_r, dt_nxt;
  logic [MAG_W-1:0]          mq_mag_r, mq_mag_nxt;
  logic                      mq_neg_r, mq_neg_nxt;
  logic [HALF_W-1:0]         mq_g_r, mq_g_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [TERM_W-1:0]  p_r, p_nxt, i_r, i_nxt, d_r, d_nxt, tot_r, tot_nxt;
  logic signed [INTEG_W-1:0] sum_r, sum_nxt;
  logic signed [QUO_W-1:0]   lo_r, lo_nxt, deriv_r, deriv_nxt;
  logic signed [DATA_W-1:0]  drive_r, drive_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]  out_drive_r, out_drive_nxt;

  logic                      in_acc;
  logic                      op_is_div;
  logic signed [TERM_W-1:0]  mq_val;
  logic [HALF_W-1:0]         mq_g_sel;
  logic [MAG_W-1:0]          mq_abs;
  logic signed [NUM_W-1:0]   div_src;
  logic [NUM_W-1:0]          div_abs;
  logic                      div_neg;
  logic [DATA_W-1:0]         div_dvsr;
  logic [DIV_W-1:0]          div_mag;
  logic                      div_start;
  logic                      div_done;
  logic signed [QUO_W-1:0]   div_q;
  logic [HALF_W-1:0]         mul_a;
  logic [2*HALF_W-1:0]       mul_p;
  logic [ACC_W-1:0]          r_full;
  logic [MAG_W-1:0]          r_mag;
  logic signed [TERM_W-1:0]  mq_res;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= GAIN_P_RST;
      gain_i_r   <= GAIN_I_RST;
      gain_d_r   <= GAIN_D_RST;
      out_low_r  <= OUT_LOW_RST;
      out_high_r <= OUT_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_P:   gain_p_r   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:   gain_i_r   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:   gain_d_r   <= cfg_data[GAIN_W-1:0];
        REG_OUT_LOW:  out_low_r  <= $signed(cfg_data);
        REG_OUT_HIGH: out_high_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier and divider
  assign op_is_div = (op_r == OP_LO) || (op_r == OP_HI) || (op_r == OP_DV);

  always_comb begin
    unique case (op_r)
      OP_P: begin
        mq_val   = TERM_W'(err_r);
        mq_g_sel = {1'b0, gain_p_r};
      end
      OP_T: begin
        mq_val   = TERM_W'(err_r);
        mq_g_sel = dt_r;
      end
      OP_I: begin
        mq_val   = TERM_W'(sum_r);
        mq_g_sel = {1'b0, gain_i_r};
      end
      OP_D: begin
        mq_val   = TERM_W'(deriv_r);
        mq_g_sel = {1'b0, gain_d_r};
      end
      default: begin
        mq_val   = '0;
        mq_g_sel = '0;
      end
    endcase
  end

  assign mq_abs = mq_val[TERM_W-1] ? MAG_W'(-mq_val) : MAG_W'(mq_val);

  always_comb begin
    unique case (op_r)
      OP_LO: begin
        div_src  = NUM_W'(out_low_r);
        div_dvsr = {1'b0, gain_i_r};
      end
      OP_HI: begin
        div_src  = NUM_W'(out_high_r);
        div_dvsr = {1'b0, gain_i_r};
      end
      OP_DV: begin
        div_src  = num_r;
        div_dvsr = dt_r;
      end
      default: begin
        div_src  = '0;
        div_dvsr = '0;
      end
    endcase
  end

  assign div_neg   = div_src[NUM_W-1];
  assign div_abs   = div_neg ? NUM_W'(-div_src) : NUM_W'(div_src);
  assign div_mag   = {div_abs, {FRAC_BITS{1'b0}}};
  assign div_start = (state_r == S_LOAD) && op_is_div;

  pawc_div #(
    .DIV_W (DIV_W)
  ) u_pawc_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (div_mag),
    .neg     (div_neg),
    .divisor (div_dvsr),
    .done    (div_done),
    .quo     (div_q)
  );

  assign mul_a = (state_r == S_MHI) ? mq_mag_r[MAG_W-1:HALF_W] : mq_mag_r[HALF_W-1:0];

  pawc_mul u_pawc_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mq_g_r),
    .p_r (mul_p)
  );

  // truncated product magnitude, capped, sign restored
  assign r_full = acc_r >> FRAC_BITS;
  assign r_mag  = (r_full > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : r_full[MAG_W-1:0];
  assign mq_res = mq_neg_r ? -$signed(r_mag) : $signed(r_mag);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    integral_nxt  = integral_r;
    prev_err_nxt  = prev_err_r;
    err_nxt       = err_r;
    num_nxt       = num_r;
    dt_nxt        = dt_r;
    mq_mag_nxt    = mq_mag_r;
    mq_neg_nxt    = mq_neg_r;
    mq_g_nxt      = mq_g_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    d_nxt         = d_r;
    tot_nxt       = tot_r;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    deriv_nxt     = deriv_r;
    drive_nxt     = drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_drive_nxt = out_drive_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_step_time == '0) begin
            drive_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            err_nxt   = ERR_W'(in_target) - ERR_W'(in_sensed);
            num_nxt   = NUM_W'(in_sensed) - NUM_W'(in_target) + NUM_W'(prev_err_r);
            dt_nxt    = in_step_time;
            op_nxt    = OP_P;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        mq_mag_nxt = mq_abs;
        mq_neg_nxt = mq_val[TERM_W-1];
        mq_g_nxt   = mq_g_sel;
        state_nxt  = op_is_div ? S_DWAIT : S_MLO;
      end
      S_MLO: begin
        state_nxt = S_MHI;
      end
      S_MHI: begin
        acc_nxt   = ACC_W'(mul_p);
        state_nxt = S_MACC;
      end
      S_MACC: begin
        acc_nxt   = acc_r + (ACC_W'(mul_p) << HALF_W);
        state_nxt = S_MFIN;
      end
      S_MFIN: begin
        unique case (op_r)
          OP_P: begin
            p_nxt     = mq_res;
            op_nxt    = OP_T;
            state_nxt = S_LOAD;
          end
          OP_T: begin
            sum_nxt = sat48(TERM_W'(integral_r) + mq_res);
            if (gain_i_r != '0) begin
              op_nxt    = OP_LO;
              state_nxt = S_LOAD;
            end else begin
              sum_nxt = '0;
              i_nxt   = '0;
              if (prev_err_r != '0) begin
                op_nxt    = OP_DV;
                state_nxt = S_LOAD;
              end else begin
                d_nxt     = '0;
                state_nxt = S_SUM;
              end
            end
          end
          OP_I: begin
            i_nxt = mq_res;
            // no derivative on the first step after a zero error
            if (prev_err_r != '0) begin
              op_nxt    = OP_DV;
              state_nxt = S_LOAD;
            end else begin
              d_nxt     = '0;
              state_nxt = S_SUM;
            end
          end
          OP_D: begin
            d_nxt     = mq_res;
            state_nxt = S_SUM;
          end
          default: state_nxt = S_SUM;
        endcase
      end
      S_DWAIT: begin
        if (div_done) begin
          unique case (op_r)
            OP_LO: begin
              lo_nxt    = div_q;
              op_nxt    = OP_HI;
              state_nxt = S_LOAD;
            end
            OP_HI: begin
              sum_nxt   = sat48(clamp64(TERM_W'(sum_r), TERM_W'(lo_r), TERM_W'(div_q)));
              op_nxt    = OP_I;
              state_nxt = S_LOAD;
            end
            OP_DV: begin
              deriv_nxt = div_q;
              op_nxt    = OP_D;
              state_nxt = S_LOAD;
            end
            default: state_nxt = S_SUM;
          endcase
        end
      end
      S_SUM: begin
        tot_nxt   = p_r + i_r + d_r;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        drive_nxt    = DATA_W'(clamp64(tot_r, TERM_W'(out_low_r), TERM_W'(out_high_r)));
        integral_nxt = sum_r;
        prev_err_nxt = sat32(err_r);
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = drive_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P;
      integral_r  <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      integral_r  <= integral_nxt;
      prev_err_r  <= prev_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    num_r       <= num_nxt;
    dt_r        <= dt_nxt;
    mq_mag_r    <= mq_mag_nxt;
    mq_neg_r    <= mq_neg_nxt;
    mq_g_r      <= mq_g_nxt;
    acc_r       <= acc_nxt;
    p_r         <= p_nxt;
    i_r         <= i_nxt;
    d_r         <= d_nxt;
    tot_r       <= tot_nxt;
    sum_r       <= sum_nxt;
    lo_r        <= lo_nxt;
    deriv_r     <= deriv_nxt;
    drive_r     <= drive_nxt;
    out_drive_r <= out_drive_nxt;
  end

endmodule

// ===== rtl/pawc_checker.sv =====
module pawc_assert
  import pawc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [DATA_W-1:0]        in_step_time,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_drive
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // output empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second item taken while busy");

  // zero timestep gives a zero drive by way of S_OUT when the output was free
  a_bad_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_step_time == '0) && !out_valid |-> ##2 (out_valid && (out_drive == '0)))
    else $error("zero timestep did not give zero drive");

endmodule

bind pid_anti_windup_controller pawc_assert u_pawc_assert (.*);
